FILE: rtl/rgbbf_pkg.sv
// Package: constants and types shared by the RGB box downscaler.
`timescale 1ns / 1ps
package rgbbf_pkg;
	localparam int MAX_OUT_WIDTH = 1024;
	localparam int BANK_DEPTH    = MAX_OUT_WIDTH / 4;
	localparam int IDX_W         = $clog2(BANK_DEPTH);
	localparam int NUM_BANKS     = 4;
	localparam int SUM_W         = 12;
	localparam int INC_W         = 10;
	localparam int PROD_W        = SUM_W + 16;
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [3:0] UNITS_3X = 4'd9;
	localparam logic [3:0] UNITS_2X = 4'd12;

	typedef enum logic [1:0] {
		REG_FRAME_BEATS   = 2'd0,
		REG_OUT_WIDTH     = 2'd1,
		REG_BOX_MODE      = 2'd2,
		REG_INVERSE_SCALE = 2'd3
	} cfg_reg_t;

	typedef logic [3*SUM_W-1:0] sum_rgb_t;
	typedef logic [3*INC_W-1:0] inc_rgb_t;

	typedef struct packed {
		logic [23:0] pixel_zero;
		logic [23:0] pixel_one;
		logic [23:0] pixel_two;
		logic [23:0] pixel_three;
		logic [2:0]  pixel_count;
	} result_t;
endpackage

FILE: rtl/rgbbf_if.sv
// Interfaces: beat input, result output and configuration write channels.
`timescale 1ns / 1ps
interface rgbbf_beat_if;
	logic        valid;
	logic        ready;
	logic [63:0] beat_low;
	logic [63:0] beat_high;
	modport source (output valid, beat_low, beat_high, input ready);
	modport sink (input valid, beat_low, beat_high, output ready);
endinterface

interface rgbbf_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_zero;
	logic [23:0] pixel_one;
	logic [23:0] pixel_two;
	logic [23:0] pixel_three;
	logic [2:0]  pixel_count;
	modport source (output valid, pixel_zero, pixel_one, pixel_two, pixel_three,
		pixel_count, input ready);
	modport sink (input valid, pixel_zero, pixel_one, pixel_two, pixel_three,
		pixel_count, output ready);
endinterface

interface rgbbf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [18:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/rgb_box_filter_downscale.sv
// Top level: RGB888 box-filter downscaler with line-buffer banks in RAM.
//
//  channel | dir | payload                                   | handshake
//  beat    | in  | beat_low, beat_high                        | valid/ready
//  result  | out | pixel_zero..pixel_three, pixel_count       | valid/ready
//  cfg     | in  | index, data                                | valid/ready
//
// One beat per clock while beat.ready is high. A beat reads the bank RAMs at accept, adds and writes back
// in the next cycle (one-deep forwarding covers back-to-back hits), multiplies in
// the next stage and lands in an 8-entry result queue the stage after.
// After reset a clearing pass zeroes all 256 bank addresses with beat.ready low.
// Beat ready drops during the clearing pass and when the result queue and in-flight results fill it.
`timescale 1ns / 1ps
module rgb_box_filter_downscale (
	input  logic clk,
	input  logic arst_n,
	rgbbf_beat_if.sink     beat,
	rgbbf_result_if.source result,
	rgbbf_cfg_if.sink      cfg
);
	import rgbbf_pkg::*;

	// configuration registers
	logic [18:0] frame_beats_q;
	logic [10:0] out_width_q;
	logic        box3_q;
	logic [15:0] inverse_scale_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_beats_q   <= 19'd388800;
			out_width_q     <= 11'd640;
			box3_q          <= 1'b1;
			inverse_scale_q <= 16'd7282;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_BEATS:   frame_beats_q   <= cfg.data;
				REG_OUT_WIDTH:     out_width_q     <= cfg.data[10:0];
				REG_BOX_MODE:      box3_q          <= cfg.data[0];
				REG_INVERSE_SCALE: inverse_scale_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// clearing pass over the banks
	logic [IDX_W:0] clr_cnt_q;
	logic           clearing;
	assign clearing = !clr_cnt_q[IDX_W];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       clr_cnt_q <= '0;
		else if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// position state
	logic [63:0] held_low_q, held_high_q;
	logic [3:0]  leftover_q;
	logic [9:0]  out_column_q;
	logic [1:0]  row_phase_q;
	logic [18:0] beat_counter_q;

	logic accept;
	logic room;
	assign beat.ready = !clearing && room;
	assign accept = beat.valid && beat.ready;

	// stage 0: unpack window and pick the pixels
	logic [4:0]   total;
	logic [3:0]   need;
	logic         do_op;
	logic [7:0]   skip;
	logic [255:0] win, shifted;
	logic [7:0]   px [8][3];
	logic [IDX_W-1:0] idx;
	logic         alt, last;
	logic [10:0]  next_col;
	logic [1:0]   phase_inc;
	inc_rgb_t     inc_bank [NUM_BANKS];
	logic [NUM_BANKS-1:0] en_bank;

	always_comb begin
		total   = {1'b0, leftover_q} + 5'd8;
		need    = box3_q ? UNITS_3X : UNITS_2X;
		do_op   = total >= {1'b0, need};
		skip    = leftover_q[3] ? 8'd0 : {(4'd8 - leftover_q), 4'd0};
		win     = {beat.beat_high, beat.beat_low, held_high_q, held_low_q};
		shifted = win >> skip;
		for (int j = 0; j < 8; j++)
			for (int k = 0; k < 3; k++)
				px[j][k] = shifted[24*j + 8*k +: 8];
		idx  = out_column_q[2 +: IDX_W];
		alt  = box3_q && (out_column_q[1:0] != 2'd0);
		last = row_phase_q == (box3_q ? 2'd2 : 2'd1);
		// per physical bank: which pixels land in it
		for (int b = 0; b < NUM_BANKS; b++) begin
			for (int k = 0; k < 3; k++) begin
				if (box3_q) begin
					inc_bank[b][INC_W*k +: INC_W] =
						INC_W'(px[3*(b%2)][k]) + INC_W'(px[3*(b%2)+1][k])
						+ INC_W'(px[3*(b%2)+2][k]);
				end else begin
					inc_bank[b][INC_W*k +: INC_W] =
						INC_W'(px[2*b][k]) + INC_W'(px[2*b+1][k]);
				end
			end
			en_bank[b] = !box3_q || (alt ? (b >= 2) : (b < 2));
		end
		next_col  = {1'b0, out_column_q} + (box3_q ? 11'd2 : 11'd4);
		phase_inc = row_phase_q + 2'd1;
		if (phase_inc == (box3_q ? 2'd3 : 2'd2))
			phase_inc = 2'd0;
	end

	// position update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_low_q     <= '0;
			held_high_q    <= '0;
			leftover_q     <= '0;
			out_column_q   <= '0;
			row_phase_q    <= '0;
			beat_counter_q <= '0;
		end else if (accept) begin
			if ({1'b0, beat_counter_q} + 20'd1 >= {1'b0, frame_beats_q}) begin
				held_low_q     <= '0;
				held_high_q    <= '0;
				leftover_q     <= '0;
				out_column_q   <= '0;
				row_phase_q    <= '0;
				beat_counter_q <= '0;
			end else begin
				held_low_q     <= beat.beat_low;
				held_high_q    <= beat.beat_high;
				leftover_q     <= do_op ? 4'(total - {1'b0, need}) : total[3:0];
				beat_counter_q <= beat_counter_q + 1'b1;
				if (do_op) begin
					if (next_col >= out_width_q) begin
						out_column_q <= '0;
						row_phase_q  <= phase_inc;
					end else begin
						out_column_q <= next_col[9:0];
					end
				end
			end
		end
	end

	// bank RAMs
	sum_rgb_t bank_mem [NUM_BANKS][BANK_DEPTH];
	sum_rgb_t rdata_s1 [NUM_BANKS];
	logic [NUM_BANKS-1:0] we;
	logic [IDX_W-1:0]     waddr;
	sum_rgb_t             wdata [NUM_BANKS];

	always_ff @(posedge clk) begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			if (we[b]) bank_mem[b][waddr] <= wdata[b];
			rdata_s1[b] <= bank_mem[b][idx];
		end
	end

	// stage 1 registers
	logic             v_s1, last_s1, mode_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [NUM_BANKS-1:0] en_s1;
	inc_rgb_t         inc_s1 [NUM_BANKS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= accept && do_op;
	end
	always_ff @(posedge clk) begin
		last_s1 <= last;
		mode_s1 <= box3_q;
		idx_s1  <= idx;
		en_s1   <= en_bank;
		inc_s1  <= inc_bank;
	end

	// forwarding record of the last item write
	logic [NUM_BANKS-1:0] fwd_en_q;
	logic [IDX_W-1:0]     fwd_idx_q;
	sum_rgb_t             fwd_data_q [NUM_BANKS];

	// stage 1: add, saturate, write back (zeros on the last row and during the clearing pass)
	sum_rgb_t new_sum [NUM_BANKS];
	sum_rgb_t old_sum;
	logic [SUM_W:0] acc;
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			old_sum = (fwd_en_q[b] && fwd_idx_q == idx_s1) ? fwd_data_q[b] : rdata_s1[b];
			for (int k = 0; k < 3; k++) begin
				acc = {1'b0, old_sum[SUM_W*k +: SUM_W]}
					+ (SUM_W+1)'(inc_s1[b][INC_W*k +: INC_W]);
				new_sum[b][SUM_W*k +: SUM_W] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
			end
		end
		if (clearing) begin
			we    = '1;
			waddr = clr_cnt_q[IDX_W-1:0];
			for (int b = 0; b < NUM_BANKS; b++) wdata[b] = '0;
		end else begin
			we    = v_s1 ? en_s1 : '0;
			waddr = idx_s1;
			for (int b = 0; b < NUM_BANKS; b++) wdata[b] = last_s1 ? '0 : new_sum[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_en_q <= '0;
		else         fwd_en_q <= (v_s1 && !clearing) ? en_s1 : '0;
	end
	always_ff @(posedge clk) begin
		fwd_idx_q  <= idx_s1;
		fwd_data_q <= wdata;
	end

	// group sums into stage 2
	logic     v_s2, mode_s2;
	sum_rgb_t grp_s2 [NUM_BANKS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1 && last_s1;
	end
	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		for (int g = 0; g < NUM_BANKS; g++) begin
			if (mode_s1)
				grp_s2[g] <= (g < 2) ? new_sum[(g % 2) + (en_s1[2] ? 2 : 0)] : '0;
			else
				grp_s2[g] <= new_sum[g];
		end
	end

	// stage 2: normalizing multiply
	logic        v_s3, mode_s3;
	logic [PROD_W-1:0] prod_s3 [2][3];
	sum_rgb_t    quad_s3 [2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		for (int g = 0; g < 2; g++)
			for (int k = 0; k < 3; k++)
				prod_s3[g][k] <= grp_s2[g][SUM_W*k +: SUM_W] * inverse_scale_q;
		quad_s3[0] <= grp_s2[2];
		quad_s3[1] <= grp_s2[3];
	end

	// stage 3: shift and clamp into a result
	result_t          res;
	logic [7:0]       chan [NUM_BANKS][3];
	logic [SUM_W-1:0] v12;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int g = 0; g < 2; g++) begin
				v12 = prod_s3[g][k][PROD_W-1:16];
				chan[g][k] = (v12 > 12'd255) ? 8'hFF : v12[7:0];
				v12 = {2'b00, quad_s3[g][SUM_W*k+2 +: SUM_W-2]};
				chan[g+2][k] = (v12 > 12'd255) ? 8'hFF : v12[7:0];
			end
		end
		res.pixel_zero  = {chan[0][2], chan[0][1], chan[0][0]};
		res.pixel_one   = {chan[1][2], chan[1][1], chan[1][0]};
		res.pixel_two   = {chan[2][2], chan[2][1], chan[2][0]};
		res.pixel_three = {chan[3][2], chan[3][1], chan[3][0]};
		res.pixel_count = mode_s3 ? 3'd2 : 3'd4;
	end

	// result queue
	result_t            fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               pop;
	logic [FIFO_AW+1:0] load;
	assign pop = result.valid && result.ready;
	assign load = (FIFO_AW+2)'(cnt_q) + (FIFO_AW+2)'(v_s1 && last_s1)
		+ (FIFO_AW+2)'(v_s2) + (FIFO_AW+2)'(v_s3);
	assign room = load < (FIFO_AW+2)'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (v_s3) fifo_mem[wr_ptr_q] <= res;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s3) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(v_s3) - (FIFO_AW+1)'(pop);
		end
	end

	assign result.valid       = cnt_q != '0;
	assign result.pixel_zero  = fifo_mem[rd_ptr_q].pixel_zero;
	assign result.pixel_one   = fifo_mem[rd_ptr_q].pixel_one;
	assign result.pixel_two   = fifo_mem[rd_ptr_q].pixel_two;
	assign result.pixel_three = fifo_mem[rd_ptr_q].pixel_three;
	assign result.pixel_count = fifo_mem[rd_ptr_q].pixel_count;

	// checks
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !beat.ready) else $error("beat taken during bank clear");
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("result queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !pop) |-> cnt_q < (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("push into full queue");
	a_s2_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1 && last_s1)) else $error("stray result in pipeline");
endmodule

FILE: test/rgb_box_filter_downscale_test.sv
// Testbench for rgb_box_filter_downscale: random beats checked against a box-filter predictor.
`timescale 1ns / 1ps
module rgb_box_filter_downscale_test;
	import rgbbf_pkg::*;

	// Predicts downscaled pixels from accepted beats and checks results in order
	class box_scoreboard;
		logic [18:0] frame_beats;
		logic [10:0] out_width;
		logic        box3;
		logic [15:0] inverse_scale;
		logic [63:0] held_low, held_high;
		int          leftover, column, row_phase, beat_cnt;
		logic [35:0] sums [4][256];
		result_t     pending_pixels [$];
		int          fails;
		int          beats_seen, results_seen;

		function new();
			frame_beats   = 19'd388800;
			out_width     = 11'd640;
			box3          = 1'b1;
			inverse_scale = 16'd7282;
			restart();
			foreach (sums[b, i]) sums[b][i] = '0;
			fails = 0;
			beats_seen = 0;
			results_seen = 0;
		endfunction

		function void restart();
			held_low  = '0;
			held_high = '0;
			leftover  = 0;
			column    = 0;
			row_phase = 0;
			beat_cnt  = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [18:0] data);
			case (idx)
				REG_FRAME_BEATS:   frame_beats = data;
				REG_OUT_WIDTH:     out_width = data[10:0];
				REG_BOX_MODE:      box3 = data[0];
				REG_INVERSE_SCALE: inverse_scale = data[15:0];
			endcase
		endfunction

		function void note_beat(logic [63:0] lo, logic [63:0] hi);
			bit          three, do_sum, alt, last;
			int          total, need, skip, idx, groups, src, sum, o, nxt, pos;
			logic [255:0] w;
			logic [7:0]  px [8][3];
			logic [23:0] pix [4];
			logic [35:0] entry;
			result_t     r;
			beats_seen++;
			three  = box3;
			total  = leftover + 8;
			need   = three ? 9 : 12;
			do_sum = total >= need;
			// large leftover uses the whole held beat
			skip   = (leftover >= 8) ? 0 : (8 - leftover) * 16;
			w = {hi, lo, held_high, held_low};
			leftover  = (do_sum ? total - need : total) & 15;
			held_low  = lo;
			held_high = hi;
			if (do_sum) begin
				idx    = (column >> 2) % 256;
				alt    = three && (column % 4 != 0);
				last   = row_phase == (three ? 2 : 1);
				groups = three ? 2 : 4;
				for (int j = 0; j < 8; j++)
					for (int k = 0; k < 3; k++) begin
						pos = skip + j * 24 + k * 8;
						px[j][k] = (pos < 256) ? w[pos +: 8] : 8'd0;
					end
				for (int g = 0; g < 4; g++) pix[g] = '0;
				for (int g = 0; g < groups; g++) begin
					src = alt ? g + 2 : g;
					entry = '0;
					for (int k = 0; k < 3; k++) begin
						sum = sums[src][idx][12*k +: 12];
						if (three)
							sum += px[3*g][k] + px[3*g+1][k] + px[3*g+2][k];
						else
							sum += px[2*g][k] + px[2*g+1][k];
						if (sum > 4095) sum = 4095;
						o = (g < 2) ? (sum * int'(inverse_scale)) >> 16 : sum >> 2;
						if (o > 255) o = 255;
						pix[g][8*k +: 8] = 8'(o);
						if (!last) entry[12*k +: 12] = 12'(sum);
					end
					sums[src][idx] = entry;
				end
				if (last) begin
					r.pixel_zero  = pix[0];
					r.pixel_one   = pix[1];
					r.pixel_two   = pix[2];
					r.pixel_three = pix[3];
					r.pixel_count = three ? 3'd2 : 3'd4;
					pending_pixels.push_back(r);
				end
				// column and row advance
				nxt = column + (three ? 2 : 4);
				if (nxt >= out_width) begin
					column = 0;
					row_phase = (row_phase + 1) & 3;
					if (row_phase == (three ? 3 : 2)) row_phase = 0;
				end else begin
					column = nxt & 1023;
				end
			end
			if (beat_cnt + 1 >= frame_beats) restart();
			else beat_cnt = (beat_cnt + 1) & 'h7FFFF;
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (pending_pixels.size() == 0) begin
				$error("result with no expected pixels pending");
				fails++;
				return;
			end
			want = pending_pixels.pop_front();
			compare("pixel_zero", want.pixel_zero, got.pixel_zero);
			compare("pixel_one", want.pixel_one, got.pixel_one);
			compare("pixel_two", want.pixel_two, got.pixel_two);
			compare("pixel_three", want.pixel_three, got.pixel_three);
			compare("pixel_count", want.pixel_count, got.pixel_count);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	rgbbf_beat_if   beat_ch ();
	rgbbf_result_if res_ch ();
	rgbbf_cfg_if    cfg_ch ();

	box_scoreboard sb;
	bit  steady_src, steady_sink, long_hold;
	int  phases;

	rgb_box_filter_downscale i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// monitors: every accepted item goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && beat_ch.valid && beat_ch.ready)
			sb.note_beat(beat_ch.beat_low, beat_ch.beat_high);
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			sb.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result({res_ch.pixel_zero, res_ch.pixel_one,
				res_ch.pixel_two, res_ch.pixel_three, res_ch.pixel_count});
	end

	// result receiver with random stalls and an occasional long hold
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = steady_sink ? 0 : $urandom_range(0, 12);
			if (long_hold) begin
				long_hold = 1'b0;
				gap = 400;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// send one beat; called and returns at a falling edge
	task automatic send_beat(logic [63:0] lo, logic [63:0] hi);
		int gap;
		gap = steady_src ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			beat_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		beat_ch.valid     <= 1'b1;
		beat_ch.beat_low  <= lo;
		beat_ch.beat_high <= hi;
		@(posedge clk);
		while (!beat_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [18:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// stop offering beats, wait for all results, then let the pipeline empty
	task automatic drain();
		beat_ch.valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic random_beats(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				steady_src  = ($urandom_range(0, 3) == 0);
				steady_sink = ($urandom_range(0, 3) == 0);
			end
			send_beat(rand_word(), rand_word());
		end
	endtask

	// random settings; some registers left as they are so mode changes mid-frame
	task automatic random_config();
		logic        mode;
		logic [18:0] frame;
		logic [10:0] width;
		logic [15:0] inv;
		mode = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: frame = 19'd1;
			1: frame = 19'h7FFFF;
			default: frame = 19'($urandom_range(20, 400));
		endcase
		case ($urandom_range(0, 5))
			0: width = 11'd2;
			1: width = 11'd1024;
			2: width = 11'($urandom_range(2, 40));
			default: width = 11'(4 * $urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 4))
			0: inv = 16'd0;
			1: inv = 16'hFFFF;
			2: inv = 16'($urandom());
			default: inv = mode ? 16'd7282 : 16'd16384;
		endcase
		if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_BEATS, frame);
		if ($urandom_range(0, 3) != 0) write_reg(REG_OUT_WIDTH, 19'(width));
		if ($urandom_range(0, 3) != 0) write_reg(REG_BOX_MODE, 19'(mode));
		if ($urandom_range(0, 3) != 0) write_reg(REG_INVERSE_SCALE, 19'(inv));
	endtask

	// stimulus
	initial begin
		sb = new();
		beat_ch.valid = 1'b0;
		beat_ch.beat_low = '0;
		beat_ch.beat_high = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FRAME_BEATS;
		cfg_ch.data = '0;
		steady_src = 1'b0;
		steady_sink = 1'b0;
		long_hold = 1'b0;
		phases = 0;
		@(posedge arst_n);
		@(negedge clk);

		// reset settings, a few beats
		send_beat('0, '0);
		send_beat('1, '1);
		send_beat(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		drain();

		// narrow 3x rows with saturating scale: extremes of the pixel bytes
		write_reg(REG_FRAME_BEATS, 19'd40);
		write_reg(REG_OUT_WIDTH, 19'd2);
		write_reg(REG_BOX_MODE, 19'd1);
		write_reg(REG_INVERSE_SCALE, 19'hFFFF);
		for (int i = 0; i < 9; i++) send_beat('1, '1);
		send_beat('0, '0);
		send_beat(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		drain();
		// 2x mode, then back to 3x mid-frame for a large leftover
		write_reg(REG_BOX_MODE, 19'd0);
		write_reg(REG_OUT_WIDTH, 19'd4);
		write_reg(REG_INVERSE_SCALE, 19'd0);
		for (int i = 0; i < 5; i++) send_beat('1, {$urandom(), $urandom()});
		drain();
		write_reg(REG_BOX_MODE, 19'd1);
		for (int i = 0; i < 5; i++) send_beat('1, '1);
		drain();

		// block fills while the receiver holds off
		write_reg(REG_FRAME_BEATS, 19'h7FFFF);
		write_reg(REG_OUT_WIDTH, 19'd2);
		write_reg(REG_INVERSE_SCALE, 19'd7282);
		steady_src = 1'b1;
		long_hold = 1'b1;
		for (int i = 0; i < 80; i++) send_beat({$urandom(), $urandom()}, {$urandom(), $urandom()});
		drain();

		// random phases
		for (int p = 0; p < 17; p++) begin
			random_config();
			random_beats(50);
			drain();
			phases++;
		end

		repeat (40) @(negedge clk);
		$display("Covered %0d beats and %0d results over %0d random setting phases,",
			sb.beats_seen, sb.results_seen, phases);
		$display("with both scale modes, width and scale extremes, and a long receiver hold.");
		if (sb.fails == 0 && sb.pending_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
